### rtl/spq_pkg.sv
package spq_pkg;

    // opcode carried in s_tuser
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_POP    = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // shift command broadcast to every cell of the chain
    typedef struct packed {
        logic ins;
        logic pop;
    } cell_ctrl_t;

endpackage

### rtl/sorted_priority_queue_top.sv
// the result of an accepted input transaction is registered and appears on the master side in the next cycle
// throughput: one transaction per cycle while the master side takes results, set by the compare and shift in the cells
// a stalled result holds the output register and stops input only while it waits
// reset (rst_n low, asynchronous) empties the queue and clears the output valid
// cell storage is not cleared; contents of cells beyond the entry count never reach the result
module sorted_priority_queue_top #(
    parameter int CAPACITY = 16,
    parameter int KEY_BITS = 8,
    parameter int TAG_BITS = 8
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // key, tag
    input  logic [((KEY_BITS + TAG_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // opcode
    input  logic [0:0] s_tuser,
    output logic m_tvalid,
    input  logic m_tready,
    // popped_key, popped_tag, occupancy
    output logic [((KEY_BITS + TAG_BITS + $clog2(CAPACITY + 1) + 7) / 8) * 8 - 1:0] m_tdata,
    // popped_valid, status
    output logic [2:0] m_tuser
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int OUT_W = KEY_BITS + TAG_BITS + CNT_W;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    logic                 accept;
    logic                 op;
    logic [KEY_BITS-1:0]  in_key;
    logic [TAG_BITS-1:0]  in_tag;
    logic                 full;
    logic                 empty;
    spq_pkg::cell_ctrl_t  ctrl;

    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 pvalid_reg;
    logic [KEY_BITS-1:0]  pkey_reg;
    logic [TAG_BITS-1:0]  ptag_reg;
    logic [1:0]           status_reg;
    logic [CNT_W-1:0]     occ_reg;

    logic                 ge_w  [CAPACITY];
    logic [KEY_BITS-1:0]  key_w [CAPACITY];
    logic [TAG_BITS-1:0]  tag_w [CAPACITY];

    // input transaction decode
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign op       = s_tuser[0];
    assign in_key   = s_tdata[KEY_BITS-1:0];
    assign in_tag   = s_tdata[KEY_BITS +: TAG_BITS];
    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign empty    = (count_reg == '0);

    assign ctrl.ins = accept && (op == spq_pkg::OP_INSERT) && !full;
    assign ctrl.pop = accept && (op == spq_pkg::OP_POP) && !empty;

    // chain of cells, head at index 0
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic                occ;
        logic                l_ge;
        logic [KEY_BITS-1:0] l_key;
        logic [TAG_BITS-1:0] l_tag;
        logic [KEY_BITS-1:0] r_key;
        logic [TAG_BITS-1:0] r_tag;

        assign occ = (CNT_W'(i) < count_reg);

        if (i == 0)
        begin : g_head
            assign l_ge  = 1'b1;
            assign l_key = in_key;
            assign l_tag = in_tag;
        end
        else
        begin : g_body
            assign l_ge  = ge_w[i-1];
            assign l_key = key_w[i-1];
            assign l_tag = tag_w[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign r_key = key_w[i];
            assign r_tag = tag_w[i];
        end
        else
        begin : g_inner
            assign r_key = key_w[i+1];
            assign r_tag = tag_w[i+1];
        end

        spq_cell #(
            .KEY_BITS (KEY_BITS),
            .TAG_BITS (TAG_BITS)
        ) u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .occupied  (occ),
            .new_key   (in_key),
            .new_tag   (in_tag),
            .left_ge   (l_ge),
            .left_key  (l_key),
            .left_tag  (l_tag),
            .right_key (r_key),
            .right_tag (r_tag),
            .ge        (ge_w[i]),
            .key       (key_w[i]),
            .tag       (tag_w[i])
        );
    end

    // entry count update
    always_comb
    begin
        count_next = count_reg;
        if (ctrl.ins)
            count_next = count_reg + CNT_W'(1);
        else if (ctrl.pop)
            count_next = count_reg - CNT_W'(1);
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pvalid_reg <= ctrl.pop;
            pkey_reg   <= ctrl.pop ? key_w[0] : '0;
            ptag_reg   <= ctrl.pop ? tag_w[0] : '0;
            occ_reg    <= count_next;
            if ((op == spq_pkg::OP_INSERT) && full)
                status_reg <= spq_pkg::ST_FULL;
            else if ((op == spq_pkg::OP_POP) && empty)
                status_reg <= spq_pkg::ST_EMPTY;
            else
                status_reg <= spq_pkg::ST_OK;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'({occ_reg, ptag_reg, pkey_reg});
    assign m_tuser  = {status_reg, pvalid_reg};

endmodule

### rtl/spq_cell.sv
module spq_cell #(
    parameter int KEY_BITS = 8,
    parameter int TAG_BITS = 8
) (
    input  logic                 clk,
    input  spq_pkg::cell_ctrl_t  ctrl,
    input  logic                 occupied,
    input  logic [KEY_BITS-1:0]  new_key,
    input  logic [TAG_BITS-1:0]  new_tag,
    input  logic                 left_ge,
    input  logic [KEY_BITS-1:0]  left_key,
    input  logic [TAG_BITS-1:0]  left_tag,
    input  logic [KEY_BITS-1:0]  right_key,
    input  logic [TAG_BITS-1:0]  right_tag,
    output logic                 ge,
    output logic [KEY_BITS-1:0]  key,
    output logic [TAG_BITS-1:0]  tag
);

    logic [KEY_BITS-1:0] key_reg;
    logic [KEY_BITS-1:0] key_next;
    logic [TAG_BITS-1:0] tag_reg;
    logic [TAG_BITS-1:0] tag_next;

    // stored entry stays ahead of the new key when its key is greater or equal
    assign ge = occupied && (key_reg >= new_key);

    // choose keep, take new entry, or shift from a neighbor
    always_comb
    begin
        key_next = key_reg;
        tag_next = tag_reg;
        if (ctrl.ins && !ge)
        begin
            if (left_ge)
            begin
                key_next = new_key;
                tag_next = new_tag;
            end
            else
            begin
                key_next = left_key;
                tag_next = left_tag;
            end
        end
        else if (ctrl.pop)
        begin
            key_next = right_key;
            tag_next = right_tag;
        end
    end

    // entry storage, no reset needed
    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        tag_reg <= tag_next;
    end

    assign key = key_reg;
    assign tag = tag_reg;

endmodule

### rtl/spq_checker.sv
module spq_checker #(
    parameter int CAPACITY = 16,
    parameter int KEY_BITS = 8,
    parameter int TAG_BITS = 8
) (
    input logic clk,
    input logic rst_n,
    input logic s_tready,
    input logic m_tvalid,
    input logic m_tready,
    input logic [((KEY_BITS + TAG_BITS + $clog2(CAPACITY + 1) + 7) / 8) * 8 - 1:0] m_tdata,
    input logic [2:0] m_tuser
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0] occ;
    logic [1:0]       status;
    logic             pvalid;

    assign occ    = m_tdata[KEY_BITS + TAG_BITS +: CNT_W];
    assign status = m_tuser[2:1];
    assign pvalid = m_tuser[0];

    // a stalled result transaction holds its contents
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // a dropped insert is only reported on a full queue
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (status == spq_pkg::ST_FULL) |-> (occ == CNT_W'(CAPACITY)) && !pvalid)
        else $error("full status with queue not full");

    // an empty pop leaves nothing stored and returns nothing
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (status == spq_pkg::ST_EMPTY) |-> (occ == '0) && !pvalid)
        else $error("empty status with entries stored");

    // a returned entry always comes with ok status and room left behind
    a_pop: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && pvalid |-> (status == spq_pkg::ST_OK) && (occ < CNT_W'(CAPACITY)))
        else $error("popped entry with bad status or occupancy");

    // input is taken whenever no result is waiting
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

endmodule

bind sorted_priority_queue_top spq_checker #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS),
    .TAG_BITS (TAG_BITS)
) u_spq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

### verif/sorted_priority_queue_top_tb.sv
`timescale 1ns / 1ps

module sorted_priority_queue_top_tb;

    localparam int CAP      = 16;
    localparam int KW       = 8;
    localparam int TW       = 8;
    localparam int OCC_W    = $clog2(CAP + 1);
    localparam int IN_W     = ((KW + TW + 7) / 8) * 8;
    localparam int OUT_W    = ((KW + TW + OCC_W + 7) / 8) * 8;
    localparam int MAX_GAP  = 16;
    localparam int WD_LIMIT = 2000;
    localparam int SEGMENTS = 18;
    localparam int SEG_LEN  = 100;

    // one expected result of the queue
    typedef struct packed {
        logic             valid;
        logic [KW-1:0]    key;
        logic [TW-1:0]    tag;
        logic [1:0]       status;
        logic [OCC_W-1:0] occupancy;
    } pop_result_t;

    logic             clk;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;   // key, tag
    logic [0:0]       s_tuser;   // opcode
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;   // popped_key, popped_tag, occupancy
    logic [2:0]       m_tuser;   // popped_valid, status

    // predicted queue contents, head at index 0
    logic [KW-1:0] model_keys [CAP];
    logic [TW-1:0] model_tags [CAP];
    int            model_count;

    pop_result_t expected_results[$];

    int  fail_count;
    int  idle_cycles;
    bit  src_no_gap;
    bit  sink_no_stall;
    int  n_inserts, n_pops, n_full_drops, n_empty_pops, n_results;

    sorted_priority_queue_top #(
        .CAPACITY(CAP),
        .KEY_BITS(KW),
        .TAG_BITS(TW)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    // clock
    initial clk = 1'b0;
    always #4 clk = ~clk;

    // sorted insert or head removal, returns the result the block should give
    function automatic pop_result_t predict_queue_step(input logic op,
                                                       input logic [KW-1:0] key,
                                                       input logic [TW-1:0] tag);
        pop_result_t r;
        int pos;
        r = '0;
        if (op == spq_pkg::OP_INSERT)
        begin
            n_inserts++;
            if (model_count >= CAP)
            begin
                r.status = spq_pkg::ST_FULL;
                n_full_drops++;
            end
            else
            begin
                // equal keys stay ahead of the new entry
                pos = 0;
                while (pos < model_count && model_keys[pos] >= key)
                    pos++;
                for (int i = model_count; i > pos; i--)
                begin
                    model_keys[i] = model_keys[i-1];
                    model_tags[i] = model_tags[i-1];
                end
                model_keys[pos] = key;
                model_tags[pos] = tag;
                model_count++;
            end
        end
        else
        begin
            n_pops++;
            if (model_count == 0)
            begin
                r.status = spq_pkg::ST_EMPTY;
                n_empty_pops++;
            end
            else
            begin
                r.valid = 1'b1;
                r.key   = model_keys[0];
                r.tag   = model_tags[0];
                for (int i = 1; i < model_count; i++)
                begin
                    model_keys[i-1] = model_keys[i];
                    model_tags[i-1] = model_tags[i];
                end
                model_count--;
            end
        end
        r.occupancy = model_count[OCC_W-1:0];
        return r;
    endfunction

    function automatic int draw_gap(input bit no_gap);
        return no_gap ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    // result check first, then prediction of a newly accepted transaction
    always @(posedge clk)
    begin
        pop_result_t exp_r;
        pop_result_t got;
        if (rst_n)
        begin
            idle_cycles = idle_cycles + 1;
            if (m_tvalid && m_tready)
            begin
                idle_cycles = 0;
                n_results++;
                got.key       = m_tdata[KW-1:0];
                got.tag       = m_tdata[KW+TW-1:KW];
                got.occupancy = m_tdata[KW+TW+OCC_W-1:KW+TW];
                got.valid     = m_tuser[0];
                got.status    = m_tuser[2:1];
                if (expected_results.size() == 0)
                begin
                    $error("result with no transaction pending: key %0h tag %0h",
                           got.key, got.tag);
                    fail_count++;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (got.valid !== exp_r.valid)
                    begin
                        $error("popped_valid expected %0d actual %0d",
                               exp_r.valid, got.valid);
                        fail_count++;
                    end
                    if (got.key !== exp_r.key)
                    begin
                        $error("popped_key expected %0h actual %0h", exp_r.key, got.key);
                        fail_count++;
                    end
                    if (got.tag !== exp_r.tag)
                    begin
                        $error("popped_tag expected %0h actual %0h", exp_r.tag, got.tag);
                        fail_count++;
                    end
                    if (got.status !== exp_r.status)
                    begin
                        $error("status expected %0d actual %0d", exp_r.status, got.status);
                        fail_count++;
                    end
                    if (got.occupancy !== exp_r.occupancy)
                    begin
                        $error("occupancy expected %0d actual %0d",
                               exp_r.occupancy, got.occupancy);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                idle_cycles = 0;
                expected_results.push_back(
                    predict_queue_step(s_tuser[0], s_tdata[KW-1:0], s_tdata[KW+TW-1:KW]));
            end
            // watchdog
            if (idle_cycles >= WD_LIMIT)
            begin
                $display("timeout after %0d cycles without a transaction", idle_cycles);
                $display("sorted_priority_queue_top test failed");
                $finish;
            end
        end
    end

    // result side stalls a random number of cycles before each transaction
    initial
    begin
        int gap;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = draw_gap(sink_no_stall);
            @(negedge clk);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!(m_tvalid && m_tready));
        end
    end

    // one input transaction, preceded by a random gap
    task automatic send_item(input logic op, input logic [KW-1:0] key,
                             input logic [TW-1:0] tag);
        int gap;
        gap = draw_gap(src_no_gap);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= IN_W'({tag, key});
        do @(posedge clk); while (!s_tready);
    endtask

    // hold off input until every pending result has come back
    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // extremes, equal keys at head and tail, pop on empty
    task automatic test_directed_extremes();
        send_item(spq_pkg::OP_INSERT, 8'h00, 8'h00);
        send_item(spq_pkg::OP_INSERT, 8'hFF, 8'hFF);
        send_item(spq_pkg::OP_INSERT, 8'hFF, 8'h01);
        send_item(spq_pkg::OP_INSERT, 8'h00, 8'hAA);
        send_item(spq_pkg::OP_INSERT, 8'h80, 8'h5A);
        repeat (5) send_item(spq_pkg::OP_POP, 8'hFF, 8'hFF);
        send_item(spq_pkg::OP_POP, 8'h00, 8'h00);
        wait_drained();
    endtask

    // fill to capacity with repeated keys, then an insert that must be dropped
    task automatic test_full_queue();
        for (int i = 0; i < CAP; i++)
            send_item(spq_pkg::OP_INSERT, 8'($urandom_range(0, 3) * 85), 8'(i));
        send_item(spq_pkg::OP_INSERT, 8'hFF, 8'hEE);
        wait_drained();
    endtask

    // random segments with varying insert bias, key spread and idling
    task automatic test_random_traffic();
        int            ins_pct;
        bit            narrow;
        logic          op;
        logic [KW-1:0] key;
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            src_no_gap    = ($urandom_range(0, 3) == 0);
            sink_no_stall = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 2))
                0:       ins_pct = 20;
                1:       ins_pct = 50;
                default: ins_pct = 80;
            endcase
            narrow = ($urandom_range(0, 1) == 1);
            for (int i = 0; i < SEG_LEN; i++)
            begin
                op  = ($urandom_range(0, 99) < ins_pct) ? spq_pkg::OP_INSERT
                                                         : spq_pkg::OP_POP;
                key = narrow ? 8'($urandom_range(0, 3) * 85) : 8'($urandom_range(0, 255));
                send_item(op, key, 8'($urandom_range(0, 255)));
            end
            wait_drained();
        end
        src_no_gap    = 1'b0;
        sink_no_stall = 1'b0;
    endtask

    // test sequence
    initial
    begin
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = spq_pkg::OP_INSERT;
        model_count   = 0;
        fail_count    = 0;
        idle_cycles   = 0;
        src_no_gap    = 1'b0;
        sink_no_stall = 1'b0;
        n_inserts     = 0;
        n_pops        = 0;
        n_full_drops  = 0;
        n_empty_pops  = 0;
        n_results     = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_extremes();
        test_full_queue();
        test_random_traffic();

        if (expected_results.size() != 0)
        begin
            $error("%0d results never arrived", expected_results.size());
            fail_count++;
        end
        $display("covered %0d results: %0d inserts (%0d dropped on full),",
                 n_results, n_inserts, n_full_drops);
        $display("%0d pops (%0d on empty), equal keys, extremes, idling on both sides",
                 n_pops, n_empty_pops);
        if (fail_count == 0)
            $display("sorted_priority_queue_top test passed");
        else
            $display("sorted_priority_queue_top test failed");
        $finish;
    end

endmodule
